[rtl/core/rcd_bcom_pkg.sv]
package rcd_bcom_pkg;

  // Input event codes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_CMD  = 1'b1;

  // DDR command kinds
  localparam logic [1:0] KIND_RD  = 2'd0;
  localparam logic [1:0] KIND_WR  = 2'd1;
  localparam logic [1:0] KIND_MRS = 2'd2;

  // Buffer command types
  localparam logic [1:0] BCOM_RD  = 2'd0;
  localparam logic [1:0] BCOM_WR  = 2'd1;
  localparam logic [1:0] BCOM_BCW = 2'd2;

  // Configuration register indexes
  localparam logic REG_RW_DELAY  = 1'b0;
  localparam logic REG_BCW_DELAY = 1'b1;

  // Control word decode
  localparam int         CW_ADDR_W     = 13;
  localparam logic [4:0] CW_SRC_PAGE   = 5'h04;
  localparam logic [4:0] CW_VAL_PAGE   = 5'h06;
  localparam logic [8:0] CW_SPACE_ADDR = 9'h106;
  localparam logic [3:0] CW_OP_WRITE   = 4'h4;

  // Reset values of the delay registers
  localparam logic [3:0] RW_DELAY_RST  = 4'd4;
  localparam logic [3:0] BCW_DELAY_RST = 4'd8;

  // One queued buffer command, without its tick stamp
  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] data;
    logic [2:0]  space;
    logic [3:0]  delay;
  } entry_t;

endpackage

[rtl/core/rcd_bcom_ram.sv]
module rcd_bcom_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/lrdimm_rcd_bcom_issue.sv]
// Buffer command issue path of an LRDIMM registering clock driver.
// The in channel carries one event per transaction: a clock tick (op 0)
// or a DDR command (op 1). Read and write commands, and command-space
// control word writes, enter a queue of QUEUE_DEPTH entries held in a
// one-port-write, one-port-read RAM, each stamped with the tick count.
// A command transaction gives no result on the out channel.
// A tick transaction reads the head entry from the RAM, then issues it
// if its delay has elapsed. The RAM read is registered, so no new event
// is accepted until the tick has left the head state.
// An issued buffer command is loaded into an output register and sits
// there on the out channel until taken. While it waits, command
// transactions are still accepted; a tick whose head is due holds in
// the head state until the register frees.
// The cfg channel writes rw_delay (index 0) and bcw_delay (index 1) and is
// always ready; write it only while the block is idle.
// Reset is synchronous: the queue empties, the sticky flags and control
// words clear and the delays return to 4 and 8. No clearing pass is run.
module lrdimm_rcd_bcom_issue import rcd_bcom_pkg::*; #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst,
  // Event channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        op,
  input  logic [1:0]  cmd_kind,
  input  logic [17:0] row_addr,
  // Issue channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  bcom_type,
  output logic [11:0] bcw_data,
  output logic [2:0]  function_space,
  output logic        dropped,
  output logic        bad_cw_op,
  // Configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_data
);

  localparam int PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
  // Wide enough that an entry's wait behind the head never wraps the stamp
  localparam int STAMP_W = $clog2(QUEUE_DEPTH + 17) + 1;
  localparam int MEM_W   = $bits(entry_t) + STAMP_W;

  localparam logic [PTR_W-1:0]  LAST_SLOT  = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [FILL_W-1:0] FULL_LEVEL = FILL_W'(QUEUE_DEPTH);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_HEAD = 1'b1;

  logic                 state;
  logic                 state_next;
  logic [3:0]           rw_delay;
  logic [3:0]           bcw_delay;
  logic [7:0]           cw_source;
  logic [7:0]           cw_value;
  logic [FILL_W-1:0]    fill_level;
  logic [PTR_W-1:0]     head_ptr;
  logic [PTR_W-1:0]     tail_ptr;
  logic [STAMP_W-1:0]   tick_cnt;
  logic                 dropped_sticky;
  logic                 bad_op_sticky;

  logic [CW_ADDR_W-1:0] cw_addr;
  logic                 cmd_acc;
  logic                 tick_acc;
  logic                 push_req;
  logic                 push_ok;
  logic                 queue_full;
  entry_t               push_ent;
  logic                 load_src;
  logic                 load_val;
  logic                 bad_op;

  logic [MEM_W-1:0]     head_word;
  entry_t               head_ent;
  logic [STAMP_W-1:0]   head_stamp;
  logic [STAMP_W-1:0]   elapsed;
  logic                 head_due;
  logic                 issue;
  logic                 out_busy;
  logic                 pop;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign cw_addr   = row_addr[CW_ADDR_W-1:0];
  assign cmd_acc   = in_valid && in_ready && (op == OP_CMD);
  assign tick_acc  = in_valid && in_ready && (op == OP_TICK);

  // Decode a DDR command into a queue push or a control word update
  always_comb begin
    push_req = 1'b0;
    push_ent = '0;
    load_src = 1'b0;
    load_val = 1'b0;
    bad_op   = 1'b0;
    if (cmd_acc) begin
      case (cmd_kind)
        KIND_RD: begin
          push_req       = 1'b1;
          push_ent.kind  = BCOM_RD;
          push_ent.delay = rw_delay;
        end
        KIND_WR: begin
          push_req       = 1'b1;
          push_ent.kind  = BCOM_WR;
          push_ent.delay = rw_delay;
        end
        KIND_MRS: begin
          if (cw_addr[12:8] == CW_SRC_PAGE) begin
            load_src = 1'b1;
          end else if (cw_addr[12:8] == CW_VAL_PAGE) begin
            load_val = 1'b1;
          end else if (cw_addr[12:4] == CW_SPACE_ADDR) begin
            if (cw_addr[3:0] == CW_OP_WRITE) begin
              push_req       = 1'b1;
              push_ent.kind  = BCOM_BCW;
              push_ent.data  = {cw_source[4:0], 7'b0} | {4'b0, cw_value};
              push_ent.space = cw_source[7:5];
              push_ent.delay = bcw_delay;
            end else begin
              bad_op = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign queue_full = (fill_level == FULL_LEVEL);
  assign push_ok    = push_req && !queue_full;

  // Pending command store: entry fields plus the tick count at push
  rcd_bcom_ram #(
    .WIDTH (MEM_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .we    (push_ok),
    .waddr (tail_ptr),
    .wdata ({push_ent, tick_cnt}),
    .re    (tick_acc),
    .raddr (head_ptr),
    .rdata (head_word)
  );

  // Head is due once as many ticks as its delay have passed since push
  assign head_ent   = entry_t'(head_word[MEM_W-1:STAMP_W]);
  assign head_stamp = head_word[STAMP_W-1:0];
  assign elapsed    = tick_cnt - head_stamp;
  assign head_due   = (elapsed >= STAMP_W'(head_ent.delay));
  assign issue      = (state == S_HEAD) && (fill_level != '0) && head_due;
  assign out_busy   = out_valid && !out_ready;
  assign pop        = issue && !out_busy;

  // Advance the tick sequence; hold in the head state while a due head is blocked by the output
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (tick_acc) begin
          state_next = S_HEAD;
        end
      end
      S_HEAD: begin
        if (!(issue && out_busy)) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      rw_delay       <= RW_DELAY_RST;
      bcw_delay      <= BCW_DELAY_RST;
      cw_source      <= '0;
      cw_value       <= '0;
      fill_level     <= '0;
      head_ptr       <= '0;
      tail_ptr       <= '0;
      tick_cnt       <= '0;
      dropped_sticky <= 1'b0;
      bad_op_sticky  <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_RW_DELAY) begin
          rw_delay <= cfg_data;
        end else begin
          bcw_delay <= cfg_data;
        end
      end
      if (load_src) begin
        cw_source <= cw_addr[7:0];
      end
      if (load_val) begin
        cw_value <= cw_addr[7:0];
      end
      if (tick_acc) begin
        tick_cnt <= tick_cnt + 1'b1;
      end
      if (push_req && queue_full) begin
        dropped_sticky <= 1'b1;
      end
      if (bad_op) begin
        bad_op_sticky <= 1'b1;
      end
      if (push_ok) begin
        tail_ptr   <= (tail_ptr == LAST_SLOT) ? '0 : tail_ptr + 1'b1;
        fill_level <= fill_level + 1'b1;
      end else if (pop) begin
        head_ptr   <= (head_ptr == LAST_SLOT) ? '0 : head_ptr + 1'b1;
        fill_level <= fill_level - 1'b1;
      end
      if (pop) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (pop) begin
      bcom_type      <= head_ent.kind;
      bcw_data       <= (head_ent.kind == BCOM_BCW) ? head_ent.data : '0;
      function_space <= (head_ent.kind == BCOM_BCW) ? head_ent.space : '0;
      dropped        <= dropped_sticky;
      bad_cw_op      <= bad_op_sticky;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_level <= FULL_LEVEL)
    else $error("queue fill level beyond depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    (fill_level == '0) |-> (head_ptr == tail_ptr))
    else $error("empty queue with head and tail apart");

  a_issue_from_head: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !$past(out_valid)) |-> ($past(state) == S_HEAD))
    else $error("result issued outside a head read");

  a_tick_reads_head: assert property (@(posedge clk) disable iff (rst)
    tick_acc |=> (state == S_HEAD))
    else $error("tick transaction did not read the head");

  a_plain_zeroes: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (bcom_type != BCOM_BCW)) |-> (bcw_data == '0 && function_space == '0))
    else $error("read or write issued with control word payload");

endmodule
